/* sv/rgnc_pkg.sv */
// Shared types, widths and helpers for the rectangle grid node coordinate block.
// No dependencies; every other file imports this package.
package rgnc_pkg;

  localparam int MAX_SIDE = 1024;
  localparam int CNT_W    = 11;
  localparam int NODE_W   = 21;
  localparam int SIZE_W   = 24;
  localparam int COORD_W  = 24;
  localparam int M_W      = 12;
  localparam int IQ_W     = $clog2(MAX_SIDE);
  localparam int IREM_W   = NODE_W - IQ_W;
  localparam int CQ_W     = SIZE_W - 1;
  localparam int CREM_W   = CNT_W + 1;
  localparam int PROD_W   = CNT_W + SIZE_W;

  typedef enum logic [1:0] {
    REG_NODES_X  = 2'd0,
    REG_NODES_Y  = 2'd1,
    REG_WIDTH_X  = 2'd2,
    REG_HEIGHT_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                  err;
    logic                  bnd;
    logic signed [M_W-1:0] mx;
    logic signed [M_W-1:0] my;
    logic signed [1:0]     nrx;
    logic signed [1:0]     nry;
  } item_t;

  typedef struct packed {
    logic [IREM_W-1:0] rem;
    logic [IQ_W-1:0]   low;
  } idiv_t;

  typedef struct packed {
    logic              neg;
    logic [CREM_W-1:0] rem;
    logic [CQ_W-1:0]   low;
  } cdiv_t;

  typedef struct packed {
    logic              err;
    logic              bnd;
    logic signed [1:0] nrx;
    logic signed [1:0] nry;
    cdiv_t             x;
    cdiv_t             y;
  } citem_t;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(MAX_SIDE)) r = CNT_W'(MAX_SIDE);
    return r;
  endfunction

endpackage

/* sv/rgnc_front.sv */
// Input stage: range check, inner/boundary split and boundary offsets.
// Depends on rgnc_pkg.
module rgnc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rgnc_pkg::NODE_W-1:0] node_number,
  input  logic [rgnc_pkg::CNT_W-1:0]  nx,
  input  logic [rgnc_pkg::CNT_W-1:0]  ny,
  output logic                        valid_r,
  output rgnc_pkg::item_t             item_r,
  output rgnc_pkg::idiv_t             div_r
);
  import rgnc_pkg::*;

  logic [NODE_W-1:0] inner, total, b, dvd;
  logic [NODE_W-1:0] x21, y21;
  logic signed [15:0] xs, ys, bs;
  item_t item_nxt;

  always_comb begin
    x21   = NODE_W'(nx);
    y21   = NODE_W'(ny);
    inner = x21 * y21;
    total = inner + (x21 << 1) + (y21 << 1);
    b     = node_number - inner;
    xs    = 16'(signed'({1'b0, nx}));
    ys    = 16'(signed'({1'b0, ny}));
    bs    = 16'(signed'({1'b0, b[12:0]}));
    dvd   = '0;
    item_nxt = '0;
    priority if (node_number == '0 || node_number > total) begin
      item_nxt.err = 1'b1;
    end else if (node_number <= inner) begin
      dvd = node_number - NODE_W'(1);
    end else begin
      item_nxt.bnd = 1'b1;
      priority if (b <= x21) begin
        item_nxt.mx  = M_W'(2 * bs - 16'sd1 - xs);
        item_nxt.my  = M_W'(ys);
        item_nxt.nry = 2'sd1;
      end else if (b <= x21 + y21) begin
        item_nxt.mx  = M_W'(xs);
        item_nxt.my  = M_W'(2 * xs + ys + 16'sd1 - 2 * bs);
        item_nxt.nrx = 2'sd1;
      end else if (b <= (x21 << 1) + y21) begin
        item_nxt.mx  = M_W'(3 * xs + 2 * ys + 16'sd1 - 2 * bs);
        item_nxt.my  = M_W'(-ys);
        item_nxt.nry = -2'sd1;
      end else begin
        item_nxt.mx  = M_W'(-xs);
        item_nxt.my  = M_W'(2 * bs - 4 * xs - 3 * ys - 16'sd1);
        item_nxt.nrx = -2'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r    <= item_nxt;
      div_r.rem <= dvd[NODE_W-1:IQ_W];
      div_r.low <= dvd[IQ_W-1:0];
    end
  end

endmodule

/* sv/rgnc_idiv_cell.sv */
// One quotient bit of the row/column split (node number minus one by nx).
// Depends on rgnc_pkg.
module rgnc_idiv_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [rgnc_pkg::CNT_W-1:0] divisor,
  input  logic                       in_valid,
  input  rgnc_pkg::item_t            in_item,
  input  rgnc_pkg::idiv_t            in_div,
  output logic                       valid_r,
  output rgnc_pkg::item_t            item_r,
  output rgnc_pkg::idiv_t            div_r
);
  import rgnc_pkg::*;

  logic [IREM_W:0] t;
  logic            ge;
  idiv_t           div_nxt;

  always_comb begin
    t  = {in_div.rem, in_div.low[IQ_W-1]};
    ge = t >= (IREM_W + 1)'(divisor);
    div_nxt.rem = ge ? IREM_W'(t - (IREM_W + 1)'(divisor)) : IREM_W'(t);
    div_nxt.low = {in_div.low[IQ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= in_item;
      div_r  <= div_nxt;
    end
  end

endmodule

/* sv/rgnc_cdiv_cell.sv */
// One quotient bit of both coordinate divisions, |m|*size by 2n, x and y lanes.
// Depends on rgnc_pkg.
module rgnc_cdiv_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [rgnc_pkg::CREM_W-1:0] dx,
  input  logic [rgnc_pkg::CREM_W-1:0] dy,
  input  logic                        in_valid,
  input  rgnc_pkg::citem_t            in_item,
  output logic                        valid_r,
  output rgnc_pkg::citem_t            item_r
);
  import rgnc_pkg::*;

  citem_t item_nxt;

  function automatic cdiv_t step(input cdiv_t c, input logic [CREM_W-1:0] d);
    logic [CREM_W:0] t;
    logic            ge;
    cdiv_t           r;
    t  = {c.rem, c.low[CQ_W-1]};
    ge = t >= (CREM_W + 1)'(d);
    r.neg = c.neg;
    r.rem = ge ? CREM_W'(t - (CREM_W + 1)'(d)) : CREM_W'(t);
    r.low = {c.low[CQ_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    item_nxt   = in_item;
    item_nxt.x = step(in_item.x, dx);
    item_nxt.y = step(in_item.y, dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* sv/rect_grid_node_coordinates.sv */
// Top level: configuration registers, cell chains, scaling and output register.
// Depends on rgnc_pkg, rgnc_front, rgnc_idiv_cell and rgnc_cdiv_cell.
//
// Takes one node request per cycle when the output side keeps up, and returns
// one result per request, in order. A request passes through two chains of
// divider cells: 10 cells split the node number into row and column, 23 cells
// form the coordinate quotients, plus front, offset, multiply and output stages.
// The whole chain stalls while a result waits.
// Registers are written through the cfg port, which is always ready; write
// them only while no request is in flight.
module rect_grid_node_coordinates (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [rgnc_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rgnc_pkg::NODE_W-1:0]         in_node_number,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rgnc_pkg::COORD_W-1:0] out_coord_x,
  output logic signed [rgnc_pkg::COORD_W-1:0] out_coord_y,
  output logic signed [1:0]                   out_normal_x,
  output logic signed [1:0]                   out_normal_y,
  output logic                                out_on_boundary,
  output logic                                out_index_error
);
  import rgnc_pkg::*;

  logic [CNT_W-1:0]  nodes_x_r, nodes_y_r, nx, ny;
  logic [SIZE_W-1:0] width_x_r, height_y_r;
  logic [CREM_W-1:0] dx, dy;
  logic              en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_x_r  <= CNT_W'(1);
      nodes_y_r  <= CNT_W'(1);
      width_x_r  <= SIZE_W'(65536);
      height_y_r <= SIZE_W'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NODES_X:  nodes_x_r  <= cfg_data[CNT_W-1:0];
        REG_NODES_Y:  nodes_y_r  <= cfg_data[CNT_W-1:0];
        REG_WIDTH_X:  width_x_r  <= cfg_data;
        REG_HEIGHT_Y: height_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nx = clamp_cnt(nodes_x_r);
  assign ny = clamp_cnt(nodes_y_r);
  assign dx = {nx, 1'b0};
  assign dy = {ny, 1'b0};

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // front and row/column chain
  logic  iv [0:IQ_W];
  item_t ii [0:IQ_W];
  idiv_t id [0:IQ_W];

  rgnc_front u_front (
    .clk, .rst_n, .en, .in_valid, .node_number(in_node_number), .nx, .ny,
    .valid_r(iv[0]), .item_r(ii[0]), .div_r(id[0])
  );

  for (genvar g = 0; g < IQ_W; g++) begin : g_idiv
    rgnc_idiv_cell u_cell (
      .clk, .rst_n, .en, .divisor(nx),
      .in_valid(iv[g]), .in_item(ii[g]), .in_div(id[g]),
      .valid_r(iv[g+1]), .item_r(ii[g+1]), .div_r(id[g+1])
    );
  end

  // inner offsets from row and column
  logic  off_valid_r;
  item_t off_r, off_nxt;

  always_comb begin
    off_nxt = ii[IQ_W];
    if (!ii[IQ_W].err && !ii[IQ_W].bnd) begin
      off_nxt.mx = signed'(M_W'({id[IQ_W].rem, 1'b1})) - signed'(M_W'(nx));
      off_nxt.my = signed'(M_W'({id[IQ_W].low, 1'b1})) - signed'(M_W'(ny));
    end
  end

  // magnitude times size
  logic             mul_valid_r;
  citem_t           mul_r, mul_nxt;
  logic [CNT_W-1:0] magx, magy;
  logic [PROD_W-1:0] px, py;

  always_comb begin
    magx = off_r.mx[M_W-1] ? CNT_W'(-off_r.mx) : CNT_W'(off_r.mx);
    magy = off_r.my[M_W-1] ? CNT_W'(-off_r.my) : CNT_W'(off_r.my);
    px   = PROD_W'(magx) * PROD_W'(width_x_r);
    py   = PROD_W'(magy) * PROD_W'(height_y_r);
    mul_nxt.err   = off_r.err;
    mul_nxt.bnd   = off_r.bnd;
    mul_nxt.nrx   = off_r.nrx;
    mul_nxt.nry   = off_r.nry;
    mul_nxt.x.neg = off_r.mx[M_W-1];
    mul_nxt.x.rem = px[PROD_W-1:CQ_W];
    mul_nxt.x.low = px[CQ_W-1:0];
    mul_nxt.y.neg = off_r.my[M_W-1];
    mul_nxt.y.rem = py[PROD_W-1:CQ_W];
    mul_nxt.y.low = py[CQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_valid_r <= 1'b0;
      mul_valid_r <= 1'b0;
    end else if (en) begin
      off_valid_r <= iv[IQ_W];
      mul_valid_r <= off_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r <= off_nxt;
      mul_r <= mul_nxt;
    end
  end

  // coordinate division chain
  logic   cv [0:CQ_W];
  citem_t ci [0:CQ_W];

  assign cv[0] = mul_valid_r;
  assign ci[0] = mul_r;

  for (genvar g = 0; g < CQ_W; g++) begin : g_cdiv
    rgnc_cdiv_cell u_cell (
      .clk, .rst_n, .en, .dx, .dy,
      .in_valid(cv[g]), .in_item(ci[g]),
      .valid_r(cv[g+1]), .item_r(ci[g+1])
    );
  end

  // floor fix-up and output register
  function automatic logic [COORD_W-1:0] fix(input cdiv_t c);
    logic [COORD_W-1:0] q;
    q = {1'b0, c.low};
    return c.neg ? (-q - COORD_W'(c.rem != '0)) : q;
  endfunction

  logic                      out_valid_r;
  logic [COORD_W-1:0]        cx_r, cy_r;
  logic signed [1:0]         nrx_r, nry_r;
  logic                      bnd_r, err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv[CQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r  <= fix(ci[CQ_W].x);
      cy_r  <= fix(ci[CQ_W].y);
      nrx_r <= ci[CQ_W].nrx;
      nry_r <= ci[CQ_W].nry;
      bnd_r <= ci[CQ_W].bnd;
      err_r <= ci[CQ_W].err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coord_x     = signed'(cx_r);
  assign out_coord_y     = signed'(cy_r);
  assign out_normal_x    = nrx_r;
  assign out_normal_y    = nry_r;
  assign out_on_boundary = bnd_r;
  assign out_index_error = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |->
      out_coord_x == '0 && out_coord_y == '0 && !out_on_boundary)
    else $error("bad node request gave non-zero result");

  a_bnd_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_on_boundary |-> (out_normal_x != '0) != (out_normal_y != '0))
    else $error("boundary node without single normal component");

  a_inner_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_on_boundary |-> out_normal_x == '0 && out_normal_y == '0)
    else $error("inner node with non-zero normal");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

endmodule

/* tb/sv/rgnc_checker.sv */
`timescale 1ns / 1ps
// Checker for rect_grid_node_coordinates: watches the cfg, node and result channels,
// predicts each result from its own register copy and compares in order. Uses rgnc_pkg.
module rgnc_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [rgnc_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [rgnc_pkg::NODE_W-1:0]         in_node_number,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [rgnc_pkg::COORD_W-1:0] out_coord_x,
  input  logic signed [rgnc_pkg::COORD_W-1:0] out_coord_y,
  input  logic signed [1:0]                   out_normal_x,
  input  logic signed [1:0]                   out_normal_y,
  input  logic                                out_on_boundary,
  input  logic                                out_index_error,
  output int                                  fail_count,
  output int                                  pending
);
  import rgnc_pkg::*;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [1:0]  nx;
    logic signed [1:0]  ny;
    logic               bnd;
    logic               err;
  } node_res_t;

  logic [10:0] cells_x, cells_y;
  logic [23:0] size_x, size_y;
  node_res_t   node_q[$];

  function automatic longint fdiv(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic longint eff_cells(logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic node_res_t node_position(logic [20:0] num);
    node_res_t r;
    longint x, y, sx, sy, inner, total, i, b, k;
    r = '0;
    x = eff_cells(cells_x);
    y = eff_cells(cells_y);
    sx = size_x;
    sy = size_y;
    i = num;
    inner = x * y;
    total = inner + 2 * (x + y);
    if (i == 0 || i > total) begin
      r.err = 1'b1;
    end else if (i <= inner) begin
      r.cx = 24'(fdiv((2 * ((i - 1) % x) + 1 - x) * sx, 2 * x));
      r.cy = 24'(fdiv((2 * ((i - 1) / x) + 1 - y) * sy, 2 * y));
    end else begin
      b = i - inner;
      r.bnd = 1'b1;
      if (b <= x) begin
        k = b - 1;
        r.cx = 24'(fdiv((2 * k + 1 - x) * sx, 2 * x));
        r.cy = 24'(fdiv(y * sy, 2 * y));
        r.ny = 2'sd1;
      end else if (b <= x + y) begin
        k = b - x - 1;
        r.cx = 24'(fdiv(x * sx, 2 * x));
        r.cy = 24'(fdiv((y - 1 - 2 * k) * sy, 2 * y));
        r.nx = 2'sd1;
      end else if (b <= 2 * x + y) begin
        k = b - x - y - 1;
        r.cx = 24'(fdiv((x - 1 - 2 * k) * sx, 2 * x));
        r.cy = 24'(fdiv(-y * sy, 2 * y));
        r.ny = -2'sd1;
      end else begin
        k = b - 2 * x - y - 1;
        r.cx = 24'(fdiv(-x * sx, 2 * x));
        r.cy = 24'(fdiv((2 * k + 1 - y) * sy, 2 * y));
        r.nx = -2'sd1;
      end
    end
    return r;
  endfunction

  assign pending = node_q.size();

  always @(posedge clk) begin
    node_res_t e, a;
    if (!rst_n) begin
      cells_x <= 11'd1;
      cells_y <= 11'd1;
      size_x <= 24'd65536;
      size_y <= 24'd65536;
      fail_count <= 0;
      node_q.delete();
    end else begin
      if (in_valid && in_ready) node_q = {node_q, node_position(in_node_number)};
      if (out_valid && out_ready) begin
        a = '{out_coord_x, out_coord_y, out_normal_x, out_normal_y,
              out_on_boundary, out_index_error};
        if (node_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", a);
          fail_count <= fail_count + 1;
        end else begin
          e = node_q.pop_front();
          if (e !== a) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", e, a);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_NODES_X:  cells_x <= cfg_data[10:0];
          REG_NODES_Y:  cells_y <= cfg_data[10:0];
          REG_WIDTH_X:  size_x <= cfg_data;
          REG_HEIGHT_Y: size_y <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench top: clock, reset, register phases and node stimulus with random gaps
// and stalls. Depends on rgnc_pkg, rect_grid_node_coordinates and rgnc_checker.
module tb;
  import rgnc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic [NODE_W-1:0] in_node_number = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_coord_x, out_coord_y;
  logic signed [1:0] out_normal_x, out_normal_y;
  logic out_on_boundary, out_index_error;
  int fail_count, pending;
  int cycle = 0;
  int cur_x = 1, cur_y = 1;

  localparam int CYCLE_LIMIT = 400000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rect_grid_node_coordinates dut (.*);
  rgnc_checker chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("rect_grid_node_coordinates test failed");
      $finish;
    end
  end

  // receiver stalls, with calm stretches
  initial begin
    int n;
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      n = gap_len();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 80)) @(negedge clk);
      repeat (n) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[SIZE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_NODES_X) cur_x = (val[10:0] == 0) ? 1 : (val[10:0] > 1024 ? 1024 : val[10:0]);
    if (idx == REG_NODES_Y) cur_y = (val[10:0] == 0) ? 1 : (val[10:0] > 1024 ? 1024 : val[10:0]);
  endtask

  task automatic setup(int unsigned nx, int unsigned ny, int unsigned wx, int unsigned hy);
    while (pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    write_reg(REG_NODES_X, nx);
    write_reg(REG_NODES_Y, ny);
    write_reg(REG_WIDTH_X, wx);
    write_reg(REG_HEIGHT_Y, hy);
  endtask

  task automatic send_node(int unsigned num);
    int n;
    n = gap_len();
    @(negedge clk);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_node_number <= num[NODE_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic random_nodes(int count);
    int unsigned total, r;
    total = cur_x * cur_y + 2 * (cur_x + cur_y);
    repeat (count) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_node($urandom_range(0, 2097151));
      else if (r == 1) send_node(total + $urandom_range(0, 3));
      else if (r < 7) send_node(cur_x * cur_y + $urandom_range(1, 2 * (cur_x + cur_y)));
      else send_node($urandom_range(1, total));
    end
    idle_input();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: one cell, unit square
    for (int i = 0; i <= 6; i++) send_node(i);
    send_node(2097151);
    idle_input();

    setup(3, 2, 24'hFFFFFF, 24'd1);
    for (int i = 0; i <= 17; i++) send_node(i);
    idle_input();

    setup(0, 2047, 0, 24'hFFFFFF);
    send_node(1);
    send_node(1024);
    send_node(1025);
    send_node(1024 + 2050);
    send_node(1024 + 2051);
    send_node(1 << 20);
    idle_input();

    setup(1024, 1024, 24'd12345, 24'hABCDEF);
    send_node(1);
    send_node(1024 * 1024);
    send_node(1024 * 1024 + 1);
    send_node(1024 * 1024 + 4096);
    send_node(1024 * 1024 + 4097);
    send_node(2097151);
    idle_input();

    for (int ph = 0; ph < 8; ph++) begin
      int unsigned nx, ny;
      nx = (ph == 7) ? $urandom_range(0, 2047) : $urandom_range(0, 12);
      ny = (ph == 6) ? $urandom_range(900, 2047) : $urandom_range(0, 12);
      setup(nx, ny, $urandom, $urandom);
      random_nodes(170);
    end

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("rect_grid_node_coordinates test passed");
    else $display("rect_grid_node_coordinates test failed");
    $finish;
  end
endmodule

/* files.f */
sv/rgnc_pkg.sv
sv/rgnc_front.sv
sv/rgnc_idiv_cell.sv
sv/rgnc_cdiv_cell.sv
sv/rect_grid_node_coordinates.sv
tb/sv/rgnc_checker.sv
tb/sv/tb.sv
